[rtl/joint_trajectory_interpolator_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the joint trajectory interpolator
// ----------------------------------------------------------------------------
`ifndef JOINT_TRAJECTORY_INTERPOLATOR_MACROS_SVH
`define JOINT_TRAJECTORY_INTERPOLATOR_MACROS_SVH

// Same-cycle implication
`define JTI_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("joint_trajectory_interpolator: check failed");

// Next-cycle implication
`define JTI_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("joint_trajectory_interpolator: check failed");

`endif

[rtl/jti_pkg.sv]
// ----------------------------------------------------------------------------
// jti_pkg
// Shared types and constants of the joint trajectory interpolator.
// ----------------------------------------------------------------------------
`default_nettype none

package jti_pkg;

    localparam int FRACTION_BITS_DEF = 32;

    localparam logic [11:0] STEP_COUNT_RST = 12'd300;
    localparam logic        LINEAR_RST     = 1'b1;
    localparam logic [31:0] THRESHOLD_RST  = 32'd655;
    localparam logic [11:0] STEP_COUNT_MIN = 12'd3;

    // 2*N*N for N up to 4095 fits here
    localparam int DEN_W = 26;

    localparam logic [1:0] CFG_STEP_COUNT = 2'd0;
    localparam logic [1:0] CFG_LINEAR     = 2'd1;
    localparam logic [1:0] CFG_THRESHOLD  = 2'd2;

    localparam logic OP_TARGET = 1'b0;
    localparam logic OP_TICK   = 1'b1;

    typedef struct packed {
        logic              opcode;
        logic signed [31:0] target_joint0;
        logic signed [31:0] target_joint1;
        logic signed [31:0] target_joint2;
    } in_t;

    typedef struct packed {
        logic signed [31:0] pos_joint0;
        logic signed [31:0] pos_joint1;
        logic signed [31:0] pos_joint2;
        logic              move_done;
    } out_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_FIRST,
        ST_SQ_MUL,
        ST_SQ_ACC,
        ST_COMPARE,
        ST_DEN,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_TICK_VEL,
        ST_TICK_POS,
        ST_EMIT
    } state_t;

endpackage

`default_nettype wire

[rtl/jti_div.sv]
// ----------------------------------------------------------------------------
// jti_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module jti_div #(
    parameter int NW = 53,
    parameter int DW = 26
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          start,
    input  wire logic [NW-1:0] dividend,
    input  wire logic [DW-1:0] divisor,
    output logic               done,
    output logic      [NW-1:0] quotient
);

    localparam int CW = $clog2(NW + 1);

    logic [DW-1:0] den_reg;
    logic [DW-1:0] rem_reg;
    logic [NW-1:0] quo_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;
    logic [DW:0]   trial;
    logic          fits;

    assign trial = {rem_reg, quo_reg[NW-1]};
    assign fits  = (trial >= {1'b0, den_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(NW);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            den_reg <= divisor;
            rem_reg <= '0;
            quo_reg <= dividend;
        end else if (busy_reg) begin
            rem_reg <= fits ? DW'(trial - {1'b0, den_reg}) : trial[DW-1:0];
            quo_reg <= {quo_reg[NW-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

[rtl/joint_trajectory_interpolator.sv]
// ----------------------------------------------------------------------------
// joint_trajectory_interpolator
// Three-joint linear or accelerate/cruise/decelerate motion profile.
// ----------------------------------------------------------------------------
// One item is worked on at a time; s_ready is high only when the sequencer is
// idle, and a finished result waits in the output register while the next item
// is taken. With s_ready low, a tick runs decode, then a velocity and a
// position pass per joint through the shared saturating adder, then the output
// stage; an idle tick runs decode only and gives no result; the first target
// runs decode, a load and the output stage; a target within the threshold
// squares each joint in turn through the shared 32x32 multiplier, then compares
// and goes to the output stage; a new target runs the bit-serial divider, which
// computes span/N or 9*span/(2*N*N) per joint, and gives no result. The output
// stage stretches while an earlier result is still waiting to transfer.
// ----------------------------------------------------------------------------
`default_nettype none

module joint_trajectory_interpolator #(
    parameter int FRACTION_BITS = jti_pkg::FRACTION_BITS_DEF
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    // input items
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire jti_pkg::in_t  s_data,
    // results
    output logic               m_valid,
    input  wire logic          m_ready,
    output jti_pkg::out_t      m_data,
    // register writes
    input  wire logic          cfg_valid,
    output logic               cfg_ready,
    input  wire logic [1:0]    cfg_index,
    input  wire logic [31:0]   cfg_data
);

    localparam int IW    = 16 + FRACTION_BITS;   // internal position width
    localparam int EXTRA = FRACTION_BITS - 16;   // fraction bits below Q16.16
    localparam int SW    = IW + 1;               // span width
    localparam int MW    = IW + 5;               // dividend width (9*span)
    localparam int DENW  = jti_pkg::DEN_W;

    localparam logic signed [MW:0] VMAX = (MW+1)'({1'b0, {(IW-1){1'b1}}});
    localparam logic signed [MW:0] VMIN = -VMAX - (MW+1)'(1);

    function automatic logic signed [IW-1:0] sat(input logic signed [MW:0] v);
        logic signed [IW-1:0] r;
        if (v > VMAX) r = VMAX[IW-1:0];
        else if (v < VMIN) r = VMIN[IW-1:0];
        else r = v[IW-1:0];
        return r;
    endfunction

    jti_pkg::state_t state_reg, state_next;

    // configuration
    logic [11:0] step_count_reg;
    logic        linear_reg;
    logic [31:0] thr_reg;

    // captured item
    logic               opcode_reg;
    logic signed [31:0] tgt_reg [3];

    // motion state
    logic signed [IW-1:0] pos_reg  [3];
    logic signed [IW-1:0] vel_reg  [3];
    logic signed [IW-1:0] acc_reg  [3];
    logic signed [31:0]   last_reg [3];
    logic [12:0]          step_idx_reg;
    logic                 moving_reg;
    logic                 started_reg;

    // sequencer scratch
    logic [1:0]  jidx_reg;
    logic [63:0] prod_reg;
    logic [65:0] dist_reg;
    logic        upd_vel_reg, vel_sub_reg, upd_pos_reg, done_flag_reg;
    logic        div_neg_reg;

    // output register
    jti_pkg::out_t out_reg;
    logic          m_valid_reg;

    // combinational helpers
    logic [11:0]          n_eff;
    logic [12:0]          k_next;
    logic [15:0]          k3;
    logic signed [32:0]   diff;
    logic [31:0]          mul_a, mul_b;
    logic [63:0]          mul_p;
    logic signed [IW-1:0] add_a, add_b;
    logic signed [SW-1:0] add_sum;
    logic signed [IW-1:0] add_sat;
    logic signed [IW-1:0] tgt_int;
    logic signed [SW-1:0] span;
    logic signed [MW-1:0] dvd;
    logic [MW-1:0]        dvd_mag;
    logic [DENW-1:0]      div_den;
    logic                 div_start;
    logic                 div_done;
    logic [MW-1:0]        div_q;
    logic signed [MW:0]   q_signed;
    logic signed [IW-1:0] q_sat;
    logic                 emit_ok;

    assign n_eff   = (step_count_reg < jti_pkg::STEP_COUNT_MIN) ?
                     jti_pkg::STEP_COUNT_MIN : step_count_reg;
    assign k_next  = step_idx_reg + 13'd1;
    // k < floor(n/3) is the same as 3*(k+1) <= n, no division needed
    assign k3      = 16'(k_next) * 16'd3 + 16'd3;
    assign emit_ok = !m_valid_reg || m_ready;

    // shared multiplier: squared joint distance, or N*N for the profile divisor
    assign diff  = 33'(tgt_reg[jidx_reg]) - 33'(last_reg[jidx_reg]);
    assign mul_a = (state_reg == jti_pkg::ST_DEN) ? {20'd0, n_eff} :
                   (diff < 0 ? 32'(-diff) : diff[31:0]);
    assign mul_b = mul_a;
    assign mul_p = mul_a * mul_b;

    // shared saturating adder: velocity pass, then position pass
    always_comb begin
        if (state_reg == jti_pkg::ST_TICK_VEL) begin
            add_a = vel_reg[jidx_reg];
            add_b = acc_reg[jidx_reg];
        end else begin
            add_a = pos_reg[jidx_reg];
            add_b = vel_reg[jidx_reg];
        end
        if (state_reg == jti_pkg::ST_TICK_VEL && vel_sub_reg) begin
            add_sum = SW'(add_a) - SW'(add_b);
        end else begin
            add_sum = SW'(add_a) + SW'(add_b);
        end
        add_sat = sat((MW+1)'(add_sum));
    end

    // divider operands and signed quotient
    assign tgt_int  = IW'(tgt_reg[jidx_reg]) <<< EXTRA;
    assign span     = SW'(tgt_int) - SW'(pos_reg[jidx_reg]);
    assign dvd      = linear_reg ? MW'(span) : ((MW'(span) <<< 3) + MW'(span));
    assign dvd_mag  = dvd[MW-1] ? MW'(-dvd) : MW'(dvd);
    assign div_den  = linear_reg ? DENW'(n_eff) : {prod_reg[DENW-2:0], 1'b0};
    assign q_signed = div_neg_reg ? -$signed({1'b0, div_q}) : $signed({1'b0, div_q});
    assign q_sat    = sat(q_signed);

    jti_div #(
        .NW (MW),
        .DW (DENW)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (dvd_mag),
        .divisor  (div_den),
        .done     (div_done),
        .quotient (div_q)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            jti_pkg::ST_IDLE: begin
                if (s_valid) state_next = jti_pkg::ST_DECODE;
            end
            jti_pkg::ST_DECODE: begin
                if (opcode_reg == jti_pkg::OP_TICK) begin
                    state_next = moving_reg ? jti_pkg::ST_TICK_VEL : jti_pkg::ST_IDLE;
                end else begin
                    state_next = started_reg ? jti_pkg::ST_SQ_MUL : jti_pkg::ST_FIRST;
                end
            end
            jti_pkg::ST_FIRST:   state_next = jti_pkg::ST_EMIT;
            jti_pkg::ST_SQ_MUL:  state_next = jti_pkg::ST_SQ_ACC;
            jti_pkg::ST_SQ_ACC: begin
                state_next = (jidx_reg == 2'd2) ? jti_pkg::ST_COMPARE : jti_pkg::ST_SQ_MUL;
            end
            jti_pkg::ST_COMPARE: begin
                state_next = (dist_reg[65:16] > 50'(thr_reg)) ? jti_pkg::ST_DEN :
                             jti_pkg::ST_EMIT;
            end
            jti_pkg::ST_DEN:       state_next = jti_pkg::ST_DIV_START;
            jti_pkg::ST_DIV_START: state_next = jti_pkg::ST_DIV_WAIT;
            jti_pkg::ST_DIV_WAIT: begin
                if (div_done) begin
                    state_next = (jidx_reg == 2'd2) ? jti_pkg::ST_IDLE :
                                 jti_pkg::ST_DIV_START;
                end
            end
            jti_pkg::ST_TICK_VEL: state_next = jti_pkg::ST_TICK_POS;
            jti_pkg::ST_TICK_POS: begin
                state_next = (jidx_reg == 2'd2) ? jti_pkg::ST_EMIT : jti_pkg::ST_TICK_VEL;
            end
            jti_pkg::ST_EMIT: begin
                if (emit_ok) state_next = jti_pkg::ST_IDLE;
            end
            default: state_next = jti_pkg::ST_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        s_ready   = (state_reg == jti_pkg::ST_IDLE);
        div_start = (state_reg == jti_pkg::ST_DIV_START);
    end

    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = out_reg;

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= jti_pkg::ST_IDLE;
            step_count_reg <= jti_pkg::STEP_COUNT_RST;
            linear_reg     <= jti_pkg::LINEAR_RST;
            thr_reg        <= jti_pkg::THRESHOLD_RST;
            step_idx_reg   <= '0;
            moving_reg     <= 1'b0;
            started_reg    <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid) begin
                case (cfg_index)
                    jti_pkg::CFG_STEP_COUNT: step_count_reg <= cfg_data[11:0];
                    jti_pkg::CFG_LINEAR:     linear_reg     <= cfg_data[0];
                    jti_pkg::CFG_THRESHOLD:  thr_reg        <= cfg_data;
                    default: ;
                endcase
            end
            if (state_reg == jti_pkg::ST_DECODE && opcode_reg == jti_pkg::OP_TICK
                && moving_reg) begin
                step_idx_reg <= k_next;
                if (k_next > 13'(n_eff)) moving_reg <= 1'b0;
            end
            if (state_reg == jti_pkg::ST_FIRST) started_reg <= 1'b1;
            if (state_reg == jti_pkg::ST_DIV_WAIT && div_done && jidx_reg == 2'd2) begin
                step_idx_reg <= '0;
                moving_reg   <= 1'b1;
            end
            if (state_reg == jti_pkg::ST_EMIT && emit_ok) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // motion state: zero after reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 3; i++) begin
                pos_reg[i]  <= '0;
                vel_reg[i]  <= '0;
                acc_reg[i]  <= '0;
                last_reg[i] <= '0;
            end
        end else begin
            case (state_reg)
                jti_pkg::ST_FIRST: begin
                    for (int i = 0; i < 3; i++) begin
                        last_reg[i] <= tgt_reg[i];
                        pos_reg[i]  <= IW'(tgt_reg[i]) <<< EXTRA;
                    end
                end
                jti_pkg::ST_DIV_WAIT: begin
                    if (div_done) begin
                        last_reg[jidx_reg] <= tgt_reg[jidx_reg];
                        if (linear_reg) begin
                            vel_reg[jidx_reg] <= q_sat;
                        end else begin
                            vel_reg[jidx_reg] <= '0;
                            acc_reg[jidx_reg] <= q_sat;
                        end
                    end
                end
                jti_pkg::ST_TICK_VEL: begin
                    if (upd_vel_reg) vel_reg[jidx_reg] <= add_sat;
                end
                jti_pkg::ST_TICK_POS: begin
                    if (upd_pos_reg) pos_reg[jidx_reg] <= add_sat;
                end
                default: ;
            endcase
        end
    end

    // scratch and payload
    always_ff @(posedge aclk) begin
        case (state_reg)
            jti_pkg::ST_IDLE: begin
                opcode_reg <= s_data.opcode;
                tgt_reg[0] <= s_data.target_joint0;
                tgt_reg[1] <= s_data.target_joint1;
                tgt_reg[2] <= s_data.target_joint2;
            end
            jti_pkg::ST_DECODE: begin
                jidx_reg <= 2'd0;
                dist_reg <= '0;
                if (opcode_reg == jti_pkg::OP_TICK) begin
                    // accelerate below N/3, cruise below 2N/3, decelerate below N
                    done_flag_reg <= (k_next > 13'(n_eff));
                    upd_pos_reg   <= (k_next < 13'(n_eff));
                    upd_vel_reg   <= !linear_reg && (k_next < 13'(n_eff)) &&
                                     (k3 <= 16'(n_eff) || k3 > 16'(n_eff) * 16'd2);
                    vel_sub_reg   <= (k3 > 16'(n_eff) * 16'd2);
                end else begin
                    done_flag_reg <= 1'b0;
                    upd_pos_reg   <= 1'b0;
                    upd_vel_reg   <= 1'b0;
                    vel_sub_reg   <= 1'b0;
                end
            end
            jti_pkg::ST_SQ_MUL: prod_reg <= mul_p;
            jti_pkg::ST_SQ_ACC: begin
                dist_reg <= dist_reg + 66'(prod_reg);
                jidx_reg <= jidx_reg + 2'd1;
            end
            jti_pkg::ST_DEN: begin
                prod_reg <= mul_p;
                jidx_reg <= 2'd0;
            end
            jti_pkg::ST_DIV_START: div_neg_reg <= dvd[MW-1];
            jti_pkg::ST_DIV_WAIT: begin
                if (div_done) jidx_reg <= jidx_reg + 2'd1;
            end
            jti_pkg::ST_TICK_POS: jidx_reg <= jidx_reg + 2'd1;
            jti_pkg::ST_EMIT: begin
                if (emit_ok) begin
                    out_reg.pos_joint0 <= pos_reg[0][EXTRA+31:EXTRA];
                    out_reg.pos_joint1 <= pos_reg[1][EXTRA+31:EXTRA];
                    out_reg.pos_joint2 <= pos_reg[2][EXTRA+31:EXTRA];
                    out_reg.move_done  <= done_flag_reg;
                end
            end
            default: ;
        endcase
    end

endmodule

`default_nettype wire

[rtl/jti_checker.sv]
// ----------------------------------------------------------------------------
// jti_checker
// Port-level checks on the joint trajectory interpolator, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

`include "joint_trajectory_interpolator_macros.svh"

module jti_checker (
    input wire logic          aclk,
    input wire logic          aresetn,
    input wire logic          s_valid,
    input wire logic          s_ready,
    input wire logic          m_valid,
    input wire logic          m_ready,
    input wire jti_pkg::out_t m_data
);

    // a stalled result holds
    `JTI_ASSERT_NXT(a_m_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data))

    // one item at a time: an input transfer closes the input side
    `JTI_ASSERT_NXT(a_s_busy, aclk, aresetn, s_valid && s_ready, !s_ready)

    // a result only appears from a busy sequencer
    `JTI_ASSERT_IMP(a_m_from_work, aclk, aresetn, $rose(m_valid), !$past(s_ready))

endmodule

bind joint_trajectory_interpolator jti_checker u_jti_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

`default_nettype wire
